FILE: design/hsv_to_rgb_converter_assert.svh
// Assertion macros shared by the HSV to RGB converter RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define HSV2RGB_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication outside reset.
`define HSV2RGB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication outside reset.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: field widths, constants, queue types.
// Depends on nothing.
`default_nettype none

package hsv2rgb_pkg;

   // field widths
   localparam int unsigned HueWidth    = 16;
   localparam int unsigned SatWidth    = 9;
   localparam int unsigned ValWidth    = 8;
   localparam int unsigned ColourWidth = 8;
   localparam int unsigned SectorWidth = 3;
   localparam int unsigned RemWidth    = 12;

   // hue geometry, 1/64 degree units
   localparam int unsigned FullTurn    = 23040;
   localparam int unsigned SectorSize  = 3840;
   localparam int unsigned NumSectors  = 6;

   // saturation of 1.0 in Q1.8
   localparam int unsigned SatOne      = 256;

   // common denominator SectorSize * SatOne = 15 * 2^16
   localparam int unsigned Denom       = SectorSize * SatOne;
   localparam int unsigned ProdWidth   = 20;
   localparam int unsigned DenomShift  = 16;
   // floor(x / 15) = (x * RecipFifteen) >> RecipShift, exact for x below 74898
   localparam int unsigned RecipFifteen = 34953;
   localparam int unsigned RecipShift   = 19;

   localparam int unsigned DefaultQueueDepth = 4;

   // sector codes
   localparam logic [SectorWidth-1:0] SecRedToYellow    = 3'd0;
   localparam logic [SectorWidth-1:0] SecYellowToGreen  = 3'd1;
   localparam logic [SectorWidth-1:0] SecGreenToCyan    = 3'd2;
   localparam logic [SectorWidth-1:0] SecCyanToBlue     = 3'd3;
   localparam logic [SectorWidth-1:0] SecBlueToMagenta  = 3'd4;
   localparam logic [SectorWidth-1:0] SecMagentaToRed   = 3'd5;

   // classified request held in the queue
   typedef struct packed {
      logic [SectorWidth-1:0] sector;
      logic [RemWidth-1:0]    rem;
      logic [SatWidth-1:0]    saturation;
      logic [ValWidth-1:0]    brightness;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

FILE: design/hsv2rgb_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on hsv2rgb_pkg.
`default_nettype none

interface hsv2rgb_req_if;
   logic                                valid;
   logic                                ready;
   logic [hsv2rgb_pkg::HueWidth-1:0]    hue;
   logic [hsv2rgb_pkg::SatWidth-1:0]    saturation;
   logic [hsv2rgb_pkg::ValWidth-1:0]    brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [hsv2rgb_pkg::ColourWidth-1:0]  red;
   logic [hsv2rgb_pkg::ColourWidth-1:0]  green;
   logic [hsv2rgb_pkg::ColourWidth-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: design/hsv2rgb_front.sv
// Front end: accepts requests, wraps hue, clamps saturation, finds sector.
// Depends on hsv2rgb_pkg, hsv2rgb_ifs and the assertion header.
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_front (
   input  logic                       clock,
   input  logic                       reset,
   hsv2rgb_req_if.sink                req_chan,
   input  hsv2rgb_pkg::q_status_type  q_status,
   output logic                       push,
   output hsv2rgb_pkg::entry_type     entry
);

   logic [hsv2rgb_pkg::HueWidth-1:0]    hue_wrap;
   logic [hsv2rgb_pkg::HueWidth-1:0]    sector_base;
   logic [hsv2rgb_pkg::HueWidth-1:0]    hue_rem;
   logic [hsv2rgb_pkg::SectorWidth-1:0] sector;

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   always_comb begin
      // a full turn or more counts as zero
      hue_wrap = (req_chan.hue >= hsv2rgb_pkg::HueWidth'(hsv2rgb_pkg::FullTurn)) ?
                 '0 : req_chan.hue;
      sector      = hsv2rgb_pkg::SecRedToYellow;
      sector_base = '0;
      for (int k = 1; k < hsv2rgb_pkg::NumSectors; k++) begin
         if (hue_wrap >= hsv2rgb_pkg::HueWidth'(k * hsv2rgb_pkg::SectorSize)) begin
            sector      = hsv2rgb_pkg::SectorWidth'(k);
            sector_base = hsv2rgb_pkg::HueWidth'(k * hsv2rgb_pkg::SectorSize);
         end
      end
      hue_rem = hue_wrap - sector_base;
   end

   always_comb begin
      entry.sector     = sector;
      entry.rem        = hue_rem[hsv2rgb_pkg::RemWidth-1:0];
      entry.saturation = (req_chan.saturation > hsv2rgb_pkg::SatWidth'(hsv2rgb_pkg::SatOne)) ?
                         hsv2rgb_pkg::SatWidth'(hsv2rgb_pkg::SatOne) : req_chan.saturation;
      entry.brightness = req_chan.brightness;
   end

   `HSV2RGB_ASSERT_IMPLY(a_front_class, clock, reset, push, (entry.sector <= hsv2rgb_pkg::SecMagentaToRed) && (entry.rem < hsv2rgb_pkg::RemWidth'(hsv2rgb_pkg::SectorSize)) && (entry.saturation <= hsv2rgb_pkg::SatWidth'(hsv2rgb_pkg::SatOne)), "front classification out of range")

endmodule

`default_nettype wire

FILE: design/hsv2rgb_queue.sv
// Short flip-flop queue between front and back ends.
// Depends on hsv2rgb_pkg and the assertion header.
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_queue #(
   parameter int unsigned Depth = hsv2rgb_pkg::DefaultQueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hsv2rgb_pkg::entry_type     push_entry,
   input  logic                       pop,
   output hsv2rgb_pkg::entry_type     pop_entry,
   output hsv2rgb_pkg::q_status_type  status
);

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   hsv2rgb_pkg::entry_type  slots_ff [Depth];
   hsv2rgb_pkg::entry_type  slot_in;
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign slot_in      = push_entry;
   assign pop_entry    = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CountWidth'(Depth));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= slot_in;
      end
   end

   `HSV2RGB_ASSERT_ALWAYS(a_queue_count, clock, reset, count_ff <= CountWidth'(Depth), "queue count above depth")
   `HSV2RGB_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, push, !status.full || pop, "push into full queue")
   `HSV2RGB_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, pop, !status.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/hsv2rgb_back.sv
// Back end: four-stage arithmetic pipeline computing l, m, n and routing by sector.
// Depends on hsv2rgb_pkg, hsv2rgb_ifs and the assertion header.
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hsv2rgb_pkg::q_status_type  q_status,
   input  hsv2rgb_pkg::entry_type     q_entry,
   output logic                       pop,
   hsv2rgb_rsp_if.source              rsp_chan
);

   localparam int unsigned LProdWidth  = hsv2rgb_pkg::SatWidth + hsv2rgb_pkg::ValWidth;
   localparam int unsigned RProdWidth  = hsv2rgb_pkg::RemWidth + hsv2rgb_pkg::SatWidth;
   localparam int unsigned ScaledWidth = hsv2rgb_pkg::ValWidth + hsv2rgb_pkg::ProdWidth;
   localparam int unsigned HiWidth     = ScaledWidth - hsv2rgb_pkg::DenomShift;
   localparam int unsigned QWidth      = HiWidth + 16;
   localparam int unsigned CW          = hsv2rgb_pkg::ColourWidth;
   localparam int unsigned VW          = hsv2rgb_pkg::ValWidth;
   localparam int unsigned SW          = hsv2rgb_pkg::SectorWidth;
   localparam int unsigned PW          = hsv2rgb_pkg::ProdWidth;

   logic adv;

   // stage 1: l and the two r*S products
   logic                    v1_ff, v1_in;
   logic [VW-1:0]           val1_ff, val1_in;
   logic [SW-1:0]           sec1_ff, sec1_in;
   logic [CW-1:0]           l1_ff, l1_in;
   logic [PW-1:0]           tm1_ff, tm1_in;
   logic [PW-1:0]           tn1_ff, tn1_in;
   logic [LProdWidth-1:0]   l_prod;
   logic [RProdWidth-1:0]   tm_prod, tn_prod;
   logic [hsv2rgb_pkg::RemWidth-1:0] rem_comp;

   // stage 2: V * (Denom - t) scaled down by 2^16
   logic                    v2_ff, v2_in;
   logic [VW-1:0]           val2_ff, val2_in;
   logic [SW-1:0]           sec2_ff, sec2_in;
   logic [CW-1:0]           l2_ff, l2_in;
   logic [HiWidth-1:0]      hm2_ff, hm2_in;
   logic [HiWidth-1:0]      hn2_ff, hn2_in;
   logic [ScaledWidth-1:0]  pm_prod, pn_prod;

   // stage 3: divide by fifteen
   logic                    v3_ff, v3_in;
   logic [VW-1:0]           val3_ff, val3_in;
   logic [SW-1:0]           sec3_ff, sec3_in;
   logic [CW-1:0]           l3_ff, l3_in;
   logic [CW-1:0]           m3_ff, m3_in;
   logic [CW-1:0]           n3_ff, n3_in;
   logic [QWidth-1:0]       qm_prod, qn_prod;

   // stage 4: routed output register
   logic                    v4_ff, v4_in;
   logic [CW-1:0]           red_ff, red_in;
   logic [CW-1:0]           green_ff, green_in;
   logic [CW-1:0]           blue_ff, blue_in;
   logic [CW-1:0]           red_rt, green_rt, blue_rt;

   assign adv = !v4_ff || rsp_chan.ready;
   assign pop = adv && !q_status.empty;

   assign rsp_chan.valid = v4_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

   // stage 1 arithmetic
   always_comb begin
      l_prod   = LProdWidth'(q_entry.brightness) *
                 LProdWidth'(hsv2rgb_pkg::SatWidth'(hsv2rgb_pkg::SatOne) - q_entry.saturation);
      rem_comp = hsv2rgb_pkg::RemWidth'(hsv2rgb_pkg::SectorSize) - q_entry.rem;
      tm_prod  = RProdWidth'(q_entry.rem) * RProdWidth'(q_entry.saturation);
      tn_prod  = RProdWidth'(rem_comp) * RProdWidth'(q_entry.saturation);
   end

   // stage 2 arithmetic
   always_comb begin
      pm_prod = ScaledWidth'(val1_ff) * ScaledWidth'(PW'(hsv2rgb_pkg::Denom) - tm1_ff);
      pn_prod = ScaledWidth'(val1_ff) * ScaledWidth'(PW'(hsv2rgb_pkg::Denom) - tn1_ff);
   end

   // stage 3 arithmetic
   always_comb begin
      qm_prod = QWidth'(hm2_ff) * QWidth'(hsv2rgb_pkg::RecipFifteen);
      qn_prod = QWidth'(hn2_ff) * QWidth'(hsv2rgb_pkg::RecipFifteen);
   end

   // sector routing
   always_comb begin
      unique case (sec3_ff)
         hsv2rgb_pkg::SecRedToYellow: begin
            red_rt = val3_ff; green_rt = n3_ff;   blue_rt = l3_ff;
         end
         hsv2rgb_pkg::SecYellowToGreen: begin
            red_rt = m3_ff;   green_rt = val3_ff; blue_rt = l3_ff;
         end
         hsv2rgb_pkg::SecGreenToCyan: begin
            red_rt = l3_ff;   green_rt = val3_ff; blue_rt = n3_ff;
         end
         hsv2rgb_pkg::SecCyanToBlue: begin
            red_rt = l3_ff;   green_rt = m3_ff;   blue_rt = val3_ff;
         end
         hsv2rgb_pkg::SecBlueToMagenta: begin
            red_rt = n3_ff;   green_rt = l3_ff;   blue_rt = val3_ff;
         end
         default: begin
            red_rt = val3_ff; green_rt = l3_ff;   blue_rt = m3_ff;
         end
      endcase
   end

   // next values: the whole pipeline moves when the output register can take data
   always_comb begin
      v1_in    = adv ? pop : v1_ff;
      val1_in  = adv ? q_entry.brightness : val1_ff;
      sec1_in  = adv ? q_entry.sector : sec1_ff;
      l1_in    = adv ? l_prod[hsv2rgb_pkg::SatWidth-2+CW:hsv2rgb_pkg::SatWidth-1] : l1_ff;
      tm1_in   = adv ? tm_prod[PW-1:0] : tm1_ff;
      tn1_in   = adv ? tn_prod[PW-1:0] : tn1_ff;

      v2_in    = adv ? v1_ff : v2_ff;
      val2_in  = adv ? val1_ff : val2_ff;
      sec2_in  = adv ? sec1_ff : sec2_ff;
      l2_in    = adv ? l1_ff : l2_ff;
      hm2_in   = adv ? pm_prod[ScaledWidth-1:hsv2rgb_pkg::DenomShift] : hm2_ff;
      hn2_in   = adv ? pn_prod[ScaledWidth-1:hsv2rgb_pkg::DenomShift] : hn2_ff;

      v3_in    = adv ? v2_ff : v3_ff;
      val3_in  = adv ? val2_ff : val3_ff;
      sec3_in  = adv ? sec2_ff : sec3_ff;
      l3_in    = adv ? l2_ff : l3_ff;
      m3_in    = adv ? qm_prod[hsv2rgb_pkg::RecipShift+CW-1:hsv2rgb_pkg::RecipShift] : m3_ff;
      n3_in    = adv ? qn_prod[hsv2rgb_pkg::RecipShift+CW-1:hsv2rgb_pkg::RecipShift] : n3_ff;

      v4_in    = adv ? v3_ff : v4_ff;
      red_in   = adv ? red_rt : red_ff;
      green_in = adv ? green_rt : green_ff;
      blue_in  = adv ? blue_rt : blue_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      val1_ff  <= val1_in;
      sec1_ff  <= sec1_in;
      l1_ff    <= l1_in;
      tm1_ff   <= tm1_in;
      tn1_ff   <= tn1_in;
      val2_ff  <= val2_in;
      sec2_ff  <= sec2_in;
      l2_ff    <= l2_in;
      hm2_ff   <= hm2_in;
      hn2_ff   <= hn2_in;
      val3_ff  <= val3_in;
      sec3_ff  <= sec3_in;
      l3_ff    <= l3_in;
      m3_ff    <= m3_in;
      n3_ff    <= n3_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   `HSV2RGB_ASSERT_IMPLY(a_back_bounds, clock, reset, v3_ff, (l3_ff <= val3_ff) && (m3_ff <= val3_ff) && (n3_ff <= val3_ff), "component above brightness")

endmodule

`default_nettype wire

FILE: design/hsv_to_rgb_converter.sv
// HSV to RGB converter: an accepted request is written into the queue, then runs through
// the back end's arithmetic pipeline into the result register and leaves it when the
// result port is ready. Throughput one request per clock while the queue has room;
// the queue and the pipeline stall independently.
// Synchronous active-high reset empties the queue and pipeline; no clearing pass.
// Depends on hsv2rgb_pkg, hsv2rgb_ifs, front, queue and back modules.
`default_nettype none

module hsv_to_rgb_converter #(
   // decoupling queue depth, at least 2 for full rate
   parameter int unsigned QueueDepth = hsv2rgb_pkg::DefaultQueueDepth
) (
   input  logic            clock,
   input  logic            reset,
   hsv2rgb_req_if.sink     req_chan,
   hsv2rgb_rsp_if.source   rsp_chan
);

   // Front: takes a request whenever the queue has room, wraps a hue of a full
   // turn or more to zero, clamps saturation to 1.0 and splits the hue into a
   // sector (0..5) and a remainder within the sector.
   hsv2rgb_pkg::q_status_type  q_status;
   hsv2rgb_pkg::entry_type     push_entry;
   hsv2rgb_pkg::entry_type     pop_entry;
   logic                       push;
   logic                       pop;

   hsv2rgb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .entry    (push_entry)
   );

   // Queue: parts request acceptance from the arithmetic, so a stalled result
   // port fills the queue before it blocks new requests.
   hsv2rgb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // Back: l = V(256-S)/256 and m, n = V(983040 - tS)/983040, the division
   // done as a shift by 16 and a reciprocal multiply by 1/15; the last stage
   // routes l, m, n and V by sector into the result register. Zero saturation
   // falls out as grey with no special path.
   hsv2rgb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_entry  (pop_entry),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: tb/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps
// Testbench for hsv_to_rgb_converter: directed and random HSV requests under random idling.
// A scoreboard class predicts each RGB result and checks it in order.
// Depends on hsv2rgb_pkg, hsv2rgb_ifs and the converter RTL.

module hsv_to_rgb_converter_tb;

   // run shape
   localparam int unsigned RandomRequests = 1730;
   localparam int unsigned SettleCycles   = 12;      // wait after the last result before the drain check
   localparam int unsigned CycleLimit     = 400000;  // several times the slowest run

   typedef struct packed {
      logic [hsv2rgb_pkg::ColourWidth-1:0] red;
      logic [hsv2rgb_pkg::ColourWidth-1:0] green;
      logic [hsv2rgb_pkg::ColourWidth-1:0] blue;
   } rgb_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the colour of each accepted request and checks the
   // results against the oldest outstanding prediction.
   // -------------------------------------------------------------------------
   class colour_scoreboard;
      rgb_type     expected_colours[$];
      int unsigned mismatches;
      int unsigned requests_seen;
      int unsigned results_checked;
      int unsigned grey_requests;
      int unsigned wrapped_hues;
      int unsigned clipped_sats;
      bit [hsv2rgb_pkg::NumSectors-1:0] sectors_hit;

      function new();
         mismatches      = 0;
         requests_seen   = 0;
         results_checked = 0;
         grey_requests   = 0;
         wrapped_hues    = 0;
         clipped_sats    = 0;
         sectors_hit     = '0;
      endfunction

      // exact six-sector conversion, truncating each component
      function rgb_type convert_hsv(logic [hsv2rgb_pkg::HueWidth-1:0] hue,
                                    logic [hsv2rgb_pkg::SatWidth-1:0] sat_in,
                                    logic [hsv2rgb_pkg::ValWidth-1:0] bri);
         longint unsigned  h, s, v, rem, l, m, n;
         logic [hsv2rgb_pkg::SectorWidth-1:0] sector;
         rgb_type          c;
         v = bri;
         s = (sat_in > hsv2rgb_pkg::SatOne) ? hsv2rgb_pkg::SatOne : sat_in;
         if (s == 0) begin
            c.red   = bri;
            c.green = bri;
            c.blue  = bri;
            return c;
         end
         h      = (hue >= hsv2rgb_pkg::FullTurn) ? 0 : hue;
         sector = hsv2rgb_pkg::SectorWidth'(h / hsv2rgb_pkg::SectorSize);
         rem    = h % hsv2rgb_pkg::SectorSize;
         l = (v * (hsv2rgb_pkg::SatOne - s)) / hsv2rgb_pkg::SatOne;
         m = (v * (hsv2rgb_pkg::Denom - rem * s)) / hsv2rgb_pkg::Denom;
         n = (v * (hsv2rgb_pkg::Denom - (hsv2rgb_pkg::SectorSize - rem) * s))
             / hsv2rgb_pkg::Denom;
         case (sector)
            hsv2rgb_pkg::SecRedToYellow: begin
               c = {bri, 8'(n), 8'(l)};
            end
            hsv2rgb_pkg::SecYellowToGreen: begin
               c = {8'(m), bri, 8'(l)};
            end
            hsv2rgb_pkg::SecGreenToCyan: begin
               c = {8'(l), bri, 8'(n)};
            end
            hsv2rgb_pkg::SecCyanToBlue: begin
               c = {8'(l), 8'(m), bri};
            end
            hsv2rgb_pkg::SecBlueToMagenta: begin
               c = {8'(n), 8'(l), bri};
            end
            default: begin
               c = {bri, 8'(l), 8'(m)};
            end
         endcase
         return c;
      endfunction

      function void note_request(logic [hsv2rgb_pkg::HueWidth-1:0] hue,
                                 logic [hsv2rgb_pkg::SatWidth-1:0] sat,
                                 logic [hsv2rgb_pkg::ValWidth-1:0] bri);
         requests_seen++;
         if (sat == 0) grey_requests++;
         if (sat > hsv2rgb_pkg::SatOne) clipped_sats++;
         if (hue >= hsv2rgb_pkg::FullTurn) wrapped_hues++;
         else if (sat != 0) sectors_hit[hue / hsv2rgb_pkg::SectorSize] = 1'b1;
         expected_colours.push_back(convert_hsv(hue, sat, bri));
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         mismatches++;
         $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
      endtask

      task check_result(rgb_type got);
         rgb_type want;
         if (expected_colours.size() == 0) begin
            report_mismatch("result with nothing outstanding, red", got.red, 0);
            return;
         end
         want = expected_colours.pop_front();
         results_checked++;
         if (got.red !== want.red)     report_mismatch("red", got.red, want.red);
         if (got.green !== want.green) report_mismatch("green", got.green, want.green);
         if (got.blue !== want.blue)   report_mismatch("blue", got.blue, want.blue);
      endtask

      task check_drained();
         while (expected_colours.size() > 0) begin
            report_mismatch("result never arrived, outstanding", expected_colours.size(), 0);
            void'(expected_colours.pop_front());
         end
      endtask

      function int unsigned outstanding();
         return expected_colours.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   hsv2rgb_req_if req_bus ();
   hsv2rgb_rsp_if rsp_bus ();

   hsv_to_rgb_converter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   colour_scoreboard colour_sb;
   bit               idling_on;   // cleared for stretches at full rate on both sides
   int unsigned      cycle_count;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  colour_sb.outstanding());
         $display("status: fail");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // -------------------------------------------------------------------------
   // Result side: samples at the edge, then drives ready for the next one.
   // Stalls run for a picked number of cycles so they land on every phase.
   // -------------------------------------------------------------------------
   initial begin : result_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            colour_sb.check_result({rsp_bus.red, rsp_bus.green, rsp_bus.blue});
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            rsp_bus.ready <= (stall_left == 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Present one request after an optional gap and hold it until accepted.
   // valid is only lowered when a gap follows, so back-to-back requests keep it high.
   task send_request(logic [hsv2rgb_pkg::HueWidth-1:0] hue,
                     logic [hsv2rgb_pkg::SatWidth-1:0] sat,
                     logic [hsv2rgb_pkg::ValWidth-1:0] bri);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= hue;
      req_bus.saturation <= sat;
      req_bus.brightness <= bri;
      do @(posedge clock); while (!req_bus.ready);
      colour_sb.note_request(hue, sat, bri);
   endtask

   // Random request, weighted towards legal hues and sector edges, with some
   // grey, clipped saturation and out-of-range hues mixed in.
   task send_random_request();
      int unsigned r;
      logic [hsv2rgb_pkg::HueWidth-1:0] hue;
      logic [hsv2rgb_pkg::SatWidth-1:0] sat;
      logic [hsv2rgb_pkg::ValWidth-1:0] bri;
      r = $urandom_range(0, 99);
      if (r < 72)
         hue = hsv2rgb_pkg::HueWidth'($urandom_range(0, hsv2rgb_pkg::FullTurn - 1));
      else if (r < 80)
         hue = hsv2rgb_pkg::HueWidth'($urandom_range(0, hsv2rgb_pkg::NumSectors - 1)
                                      * hsv2rgb_pkg::SectorSize + $urandom_range(0, 2));
      else if (r < 86)
         hue = hsv2rgb_pkg::HueWidth'($urandom_range(0, hsv2rgb_pkg::NumSectors - 1)
                                      * hsv2rgb_pkg::SectorSize
                                      + $urandom_range(hsv2rgb_pkg::SectorSize - 3,
                                                       hsv2rgb_pkg::SectorSize - 1));
      else
         hue = hsv2rgb_pkg::HueWidth'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 8)
         sat = '0;
      else if (r < 16)
         sat = hsv2rgb_pkg::SatWidth'(hsv2rgb_pkg::SatOne);
      else if (r < 24)
         sat = hsv2rgb_pkg::SatWidth'($urandom_range(hsv2rgb_pkg::SatOne + 1, 511));
      else
         sat = hsv2rgb_pkg::SatWidth'($urandom_range(1, hsv2rgb_pkg::SatOne - 1));
      r = $urandom_range(0, 99);
      if (r < 5)       bri = '0;
      else if (r < 10) bri = '1;
      else             bri = hsv2rgb_pkg::ValWidth'($urandom_range(0, 255));
      send_request(hue, sat, bri);
   endtask

   // hold off new requests until every outstanding result is back
   task wait_for_results();
      while (colour_sb.outstanding() > 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      colour_sb = new();
      idling_on = 1'b1;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.hue        <= '0;
      req_bus.saturation <= '0;
      req_bus.brightness <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: grey, every sector from its first hue, wrapped hue, clipped
      // saturation, black and full brightness, all-zero and all-one fields
      send_request(0, 0, 255);
      send_request(12345, 0, 77);
      send_request(0, 256, 255);
      send_request(3839, 256, 255);
      send_request(3840, 256, 255);
      send_request(7680, 256, 200);
      send_request(11520, 256, 255);
      send_request(15360, 128, 255);
      send_request(19200, 256, 255);
      send_request(23039, 256, 255);
      send_request(23040, 256, 255);
      send_request(65535, 200, 255);
      send_request(1920, 257, 255);
      send_request(5000, 511, 128);
      send_request(9000, 1, 255);
      send_request(14000, 255, 255);
      send_request(21000, 100, 0);
      send_request(17000, 300, 1);
      send_request(65535, 511, 255);
      send_request(0, 0, 0);

      // sender waits for a full drain before the random part
      req_bus.valid <= 1'b0;
      wait_for_results();

      // random, idling on both sides
      repeat (RandomRequests / 2) send_random_request();
      req_bus.valid <= 1'b0;
      wait_for_results();

      // full rate: no gaps, no stalls
      idling_on = 1'b0;
      repeat (RandomRequests / 4) send_random_request();
      idling_on = 1'b1;

      // random again, idling back on, straight on without a drain
      repeat (RandomRequests - RandomRequests / 2 - RandomRequests / 4)
         send_random_request();
      req_bus.valid <= 1'b0;

      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      colour_sb.check_drained();

      $display("covered %0d requests, %0d results checked; %0d grey, %0d wrapped hues,",
               colour_sb.requests_seen, colour_sb.results_checked,
               colour_sb.grey_requests, colour_sb.wrapped_hues);
      $display("%0d clipped saturations, sectors hit 6'b%b, %0d mismatches",
               colour_sb.clipped_sats, colour_sb.sectors_hit, colour_sb.mismatches);
      if (colour_sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
